// File: rtl/edsim_pkg.sv
package edsim_pkg;

   localparam int DEF_MAX_LEN = 32;
   localparam int OUT_W       = 6;
   localparam int OUT_MAX     = 63;
   localparam int THR_W       = 7;
   localparam int SIM_SCALE   = 100;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [THR_W-1:0] THR_RESET = 7'd80;
   localparam logic [THR_W-1:0] THR_LIMIT = 7'd100;

   // register index, taken from paddr[2]
   localparam logic REG_THRESHOLD = 1'b0;

   localparam logic [1:0] OP_FIRST   = 2'd0;
   localparam logic [1:0] OP_SECOND  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

// File: rtl/edsim_ram.sv
module edsim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/edsim_cell.sv
module edsim_cell import edsim_pkg::*; #(
   parameter int LW = 6
) (
   input  logic [LW-1:0] above,
   input  logic [LW-1:0] left,
   input  logic [LW-1:0] diag,
   input  logic [7:0]    char_a,
   input  logic [7:0]    char_b,
   output logic [LW-1:0] cost
);

   logic [LW:0] del_c;
   logic [LW:0] ins_c;
   logic [LW:0] sub_c;
   logic [LW:0] min_ab;
   logic [LW:0] min_all;

   always_comb begin
      del_c   = {1'b0, above} + (LW+1)'(1);
      ins_c   = {1'b0, left} + (LW+1)'(1);
      sub_c   = {1'b0, diag} + (LW+1)'(char_a != char_b);
      min_ab  = (del_c < ins_c) ? del_c : ins_c;
      min_all = (min_ab < sub_c) ? min_ab : sub_c;
      cost    = min_all[LW-1:0];
   end

endmodule

// File: rtl/edsim_match.sv
module edsim_match import edsim_pkg::*; #(
   parameter int LW = 6
) (
   input  logic             clock,
   input  logic [LW-1:0]    len,
   input  logic [LW-1:0]    edit_dist,
   input  logic [THR_W-1:0] threshold,
   output logic             is_match
);

   localparam int PW = LW + THR_W;

   logic [LW-1:0] diff;
   logic [PW-1:0] sim_ff;
   logic [PW-1:0] sim_in;
   logic [PW-1:0] need_ff;
   logic [PW-1:0] need_in;
   logic          empty_ff;
   logic          empty_in;
   logic          thr_ok_ff;
   logic          thr_ok_in;

   always_comb begin
      diff      = len - edit_dist;
      sim_in    = PW'(diff) * PW'(SIM_SCALE);
      need_in   = PW'(threshold) * PW'(len);
      empty_in  = (len == '0);
      thr_ok_in = (threshold <= THR_LIMIT);
   end

   always_ff @(posedge clock) begin
      sim_ff    <= sim_in;
      need_ff   <= need_in;
      empty_ff  <= empty_in;
      thr_ok_ff <= thr_ok_in;
   end

   assign is_match = empty_ff ? thr_ok_ff : (sim_ff >= need_ff);

endmodule

// File: rtl/edit_distance_similarity_top.sv
// Load words (opcodes 0, 1 and unused 3) are taken only while the sequencer is idle.
// A compute word steps through the init, row, cell read, cell write and multiply states,
// with the one shared cost cell and a cell read state for the row RAM before each write.
// The result sits in an output register; a new word is taken while it waits.
// Synchronous active-high reset clears the sequencer, lengths, overflow flag,
// result valid and sets the threshold to 80; string and row RAMs are not cleared.
module edit_distance_similarity_top import edsim_pkg::*; #(
   parameter int MAX_LEN = DEF_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_char_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_distance,
   output logic [OUT_W-1:0]  rsp_longer_length,
   output logic              rsp_is_match,
   output logic              rsp_overflow,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   state_type state_ff, state_in;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [LW-1:0]    len_a_ff, len_a_in;
   logic [LW-1:0]    len_b_ff, len_b_in;
   logic             ovf_ff, ovf_in;
   logic [LW-1:0]    i_ff, i_in;
   logic [LW-1:0]    j_ff, j_in;
   logic [LW-1:0]    left_ff, left_in;
   logic [LW-1:0]    diag_ff, diag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [OUT_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_match_ff, rsp_match_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic          req_take;
   logic          csr_wr;
   logic          out_free;
   logic [LW-1:0] i_m1;
   logic [LW-1:0] j_m1;
   logic [LW-1:0] longer;
   logic [LW-1:0] edit_dist;
   logic          match;

   logic          a_we;
   logic [AW-1:0] a_waddr;
   logic [7:0]    a_rdata;
   logic          b_we;
   logic [AW-1:0] b_waddr;
   logic [7:0]    b_rdata;
   logic          c_we;
   logic [LW-1:0] c_waddr;
   logic [LW-1:0] c_wdata;
   logic [LW-1:0] c_rdata;
   logic [LW-1:0] cell_cost;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_THRESHOLD) ? CSR_DW'(thr_ff) : '0;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign i_m1      = i_ff - LW'(1);
   assign j_m1      = j_ff - LW'(1);
   assign longer    = (len_a_ff > len_b_ff) ? len_a_ff : len_b_ff;
   assign edit_dist = (len_a_ff == '0) ? len_b_ff : left_ff;

   edsim_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (req_char_byte),
      .rd_addr (i_m1[AW-1:0]),
      .rd_data (a_rdata)
   );

   edsim_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (req_char_byte),
      .rd_addr (j_m1[AW-1:0]),
      .rd_data (b_rdata)
   );

   edsim_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_ram_row (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (j_ff),
      .rd_data (c_rdata)
   );

   edsim_cell #(.LW(LW)) u_cell (
      .above  (c_rdata),
      .left   (left_ff),
      .diag   (diag_ff),
      .char_a (a_rdata),
      .char_b (b_rdata),
      .cost   (cell_cost)
   );

   edsim_match #(.LW(LW)) u_match (
      .clock     (clock),
      .len       (longer),
      .edit_dist (edit_dist),
      .threshold (thr_ff),
      .is_match  (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_opcode == OP_COMPUTE) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (j_ff == len_b_ff) begin
               state_in = (len_a_ff == '0) ? ST_MUL : ST_ROW;
            end
         end
         ST_ROW: begin
            if (len_b_ff != '0) begin
               state_in = ST_CELL_RD;
            end else if (i_ff == len_a_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_CELL_RD: state_in = ST_CELL_WR;
         ST_CELL_WR: begin
            if (j_ff != len_b_ff) begin
               state_in = ST_CELL_RD;
            end else if (i_ff == len_a_ff) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      thr_in       = thr_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_match_in = rsp_match_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      a_we         = 1'b0;
      a_waddr      = len_a_ff[AW-1:0];
      b_we         = 1'b0;
      b_waddr      = len_b_ff[AW-1:0];
      c_we         = 1'b0;
      c_waddr      = j_ff;
      c_wdata      = j_ff;

      if (csr_wr && paddr[2] == REG_THRESHOLD) begin
         thr_in = pwdata[THR_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_opcode)
                  OP_FIRST: begin
                     if (len_a_ff < LW'(MAX_LEN)) begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + LW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_SECOND: begin
                     if (len_b_ff < LW'(MAX_LEN)) begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + LW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_COMPUTE: j_in = '0;
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            c_we = 1'b1;
            j_in = j_ff + LW'(1);
            i_in = LW'(1);
         end
         ST_ROW: begin
            c_we    = 1'b1;
            c_waddr = '0;
            c_wdata = i_ff;
            left_in = i_ff;
            diag_in = i_m1;
            j_in    = LW'(1);
            if (len_b_ff == '0 && i_ff != len_a_ff) begin
               i_in = i_ff + LW'(1);
            end
         end
         ST_CELL_RD: ;
         ST_CELL_WR: begin
            c_we    = 1'b1;
            c_wdata = cell_cost;
            left_in = cell_cost;
            diag_in = c_rdata;
            if (j_ff != len_b_ff) begin
               j_in = j_ff + LW'(1);
            end else if (i_ff != len_a_ff) begin
               i_in = i_ff + LW'(1);
            end
         end
         ST_MUL: ;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = (32'(edit_dist) > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                                               : OUT_W'(edit_dist);
               rsp_len_in   = (32'(longer) > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(longer);
               rsp_match_in = match;
               rsp_ovf_in   = ovf_ff;
               len_a_in     = '0;
               len_b_in     = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      left_ff      <= left_in;
      diag_ff      <= diag_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_longer_length = rsp_len_ff;
   assign rsp_is_match      = rsp_match_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

// File: verif/edit_distance_similarity_top_tb.sv
`timescale 1ns / 100ps

module edit_distance_similarity_top_tb import edsim_pkg::*;;

   localparam int MAX_LEN = DEF_MAX_LEN;
   localparam int WORD_TARGET = 1900;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_AW-1:0] THR_ADDR = {REG_THRESHOLD, 2'b00};

   typedef logic [7:0] bytes_type[$];

   typedef struct {
      logic [OUT_W-1:0] distance;
      logic [OUT_W-1:0] longer_length;
      logic             is_match;
      logic             overflow;
   } score_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_opcode = OP_FIRST;
   logic [7:0]        req_char_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [OUT_W-1:0]  rsp_distance;
   logic [OUT_W-1:0]  rsp_longer_length;
   logic              rsp_is_match;
   logic              rsp_overflow;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   // model state
   logic [7:0]       first_bytes[MAX_LEN];
   logic [7:0]       second_bytes[MAX_LEN];
   int               first_len = 0;
   int               second_len = 0;
   logic             dropped_byte = 1'b0;
   logic [THR_W-1:0] thr_model = THR_RESET;

   score_type expected_scores[$];
   score_type oldest_score;
   int     error_count = 0;
   int     words_sent = 0;
   int     idle_cycles = 0;
   int     rsp_stall_left = 0;
   bit     calm = 1'b0;

   edit_distance_similarity_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_char_byte(req_char_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_longer_length(rsp_longer_length),
      .rsp_is_match(rsp_is_match),
      .rsp_overflow(rsp_overflow),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int edit_cost();
      int row[MAX_LEN+1];
      int diag, up, best;
      for (int j = 0; j <= second_len; j++) row[j] = j;
      for (int i = 1; i <= first_len; i++) begin
         diag = row[0];
         row[0] = i;
         for (int j = 1; j <= second_len; j++) begin
            up = row[j];
            best = up + 1;
            if (row[j-1] + 1 < best) best = row[j-1] + 1;
            if (diag + int'(first_bytes[i-1] != second_bytes[j-1]) < best)
               best = diag + int'(first_bytes[i-1] != second_bytes[j-1]);
            row[j] = best;
            diag = up;
         end
      end
      return row[second_len];
   endfunction

   function automatic void score_word(logic [1:0] op, logic [7:0] b);
      score_type s;
      int dist_val, len;
      case (op)
         OP_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_bytes[first_len] = b;
               first_len++;
            end else dropped_byte = 1'b1;
         end
         OP_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_bytes[second_len] = b;
               second_len++;
            end else dropped_byte = 1'b1;
         end
         OP_COMPUTE: begin
            dist_val = edit_cost();
            len = (first_len > second_len) ? first_len : second_len;
            if (len == 0) s.is_match = (thr_model <= THR_LIMIT);
            else s.is_match = (SIM_SCALE * (len - dist_val) >= int'(thr_model) * len);
            s.distance = (dist_val > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : dist_val[OUT_W-1:0];
            s.longer_length = (len > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : len[OUT_W-1:0];
            s.overflow = dropped_byte;
            expected_scores.insert(expected_scores.size(), s);
            first_len = 0;
            second_len = 0;
            dropped_byte = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // returns at a falling edge with valid still high
   task automatic send_word(input logic [1:0] op, input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_char_byte = b;
      do @(posedge clock); while (!req_ready);
      score_word(op, b);
      if (op != OP_UNUSED) words_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      drain();
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = THR_ADDR;
      pwdata = CSR_DW'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      thr_model = value;
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DW'(value)) begin
         $error("match_threshold: expected %0d, got %0d", value, prdata);
         error_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic send_pair(input bytes_type a, input bytes_type b, input bit noisy);
      int i, j;
      i = 0;
      j = 0;
      while (i < a.size() || j < b.size()) begin
         if (noisy && $urandom_range(0, 99) < 4)
            send_word(OP_UNUSED, 8'($urandom_range(0, 255)));
         if (i < a.size() && (j >= b.size() || $urandom_range(0, 1) == 1)) begin
            send_word(OP_FIRST, a[i]);
            i++;
         end else begin
            send_word(OP_SECOND, b[j]);
            j++;
         end
      end
      send_word(OP_COMPUTE, 8'($urandom_range(0, 255)));
   endtask

   function automatic bytes_type random_bytes(int len, bit few_symbols);
      bytes_type q;
      logic [7:0] symbols[4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      for (int k = 0; k < len; k++)
         q.insert(q.size(), few_symbols ? symbols[$urandom_range(0, 3)]
                                        : 8'($urandom_range(0, 255)));
      return q;
   endfunction

   function automatic bytes_type mutate(bytes_type src, int edits);
      bytes_type q;
      int pos;
      q = src;
      repeat (edits) begin
         case ($urandom_range(0, 2))
            0: if (q.size() > 0) q[$urandom_range(0, q.size()-1)] = 8'($urandom_range(0, 255));
            1: q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
            default: if (q.size() > 0) begin
               pos = $urandom_range(0, q.size()-1);
               q.delete(pos);
            end
         endcase
      end
      while (q.size() > MAX_LEN + 6) q.delete(q.size() - 1);
      return q;
   endfunction

   function automatic int random_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, 6);
      if (r < 88) return $urandom_range(7, 16);
      if (r < 97) return $urandom_range(17, MAX_LEN);
      return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
   endfunction

   task automatic random_pair();
      bytes_type a, b;
      int r;
      a = random_bytes(random_len(), $urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 55) b = mutate(a, $urandom_range(0, 4));
      else if (r < 85) b = random_bytes(random_len(), $urandom_range(0, 1));
      else b = a;
      if ($urandom_range(0, 1) == 1) send_pair(a, b, 1'b1);
      else send_pair(b, a, 1'b1);
   endtask

   task automatic test_directed();
      send_word(OP_COMPUTE, 8'h00);
      send_word(OP_UNUSED, 8'hFF);
      send_word(OP_UNUSED, 8'h00);
      send_pair('{8'h00, 8'hFF}, '{8'hFF}, 1'b0);
      send_pair('{8'h5A, 8'hC3}, '{8'h5A, 8'hC3}, 1'b0);
      send_word(OP_FIRST, 8'h01);
      send_word(OP_UNUSED, 8'h7E);
      send_word(OP_FIRST, 8'h02);
      send_word(OP_FIRST, 8'h03);
      send_word(OP_COMPUTE, 8'hFF);
      send_word(OP_SECOND, 8'h80);
      send_word(OP_COMPUTE, 8'h55);
      send_pair('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, '{8'h11, 8'h22, 8'h3F, 8'h44, 8'h55},
                1'b0);
   endtask

   task automatic test_full_strings();
      send_pair(random_bytes(MAX_LEN + 2, 1'b0), random_bytes(MAX_LEN, 1'b0), 1'b0);
      send_pair(random_bytes(MAX_LEN, 1'b1), random_bytes(MAX_LEN, 1'b1), 1'b0);
      send_pair(random_bytes(0, 1'b0), random_bytes(MAX_LEN + 5, 1'b0), 1'b0);
      send_pair(random_bytes(MAX_LEN, 1'b0), random_bytes(1, 1'b0), 1'b0);
   endtask

   task automatic test_thresholds();
      logic [THR_W-1:0] levels[6] = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd99, 7'd50};
      foreach (levels[k]) begin
         write_threshold(levels[k]);
         send_word(OP_COMPUTE, 8'h00);
         send_pair('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, '{8'h01, 8'h02, 8'h07, 8'h04, 8'h05},
                   1'b0);
         send_pair('{8'hFF}, '{8'hFF}, 1'b0);
         random_pair();
      end
   endtask

   task automatic test_random();
      int phase_start;
      phase_start = words_sent;
      while (words_sent < WORD_TARGET) begin
         calm = ($urandom_range(0, 9) == 0);
         random_pair();
         if (words_sent - phase_start > 200) begin
            calm = 1'b0;
            if ($urandom_range(0, 99) < 25)
               write_threshold(($urandom_range(0, 1) == 1) ? THR_LIMIT : 7'd0);
            else write_threshold(7'($urandom_range(40, 127)));
            phase_start = words_sent;
         end
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready = 1'b1;
         rsp_stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            $error("result word with none expected");
            error_count++;
         end else begin
            oldest_score = expected_scores.pop_front();
            if (rsp_distance !== oldest_score.distance) begin
               $error("distance: expected %0d, got %0d", oldest_score.distance, rsp_distance);
               error_count++;
            end
            if (rsp_longer_length !== oldest_score.longer_length) begin
               $error("longer_length: expected %0d, got %0d", oldest_score.longer_length,
                      rsp_longer_length);
               error_count++;
            end
            if (rsp_is_match !== oldest_score.is_match) begin
               $error("is_match: expected %0d, got %0d", oldest_score.is_match, rsp_is_match);
               error_count++;
            end
            if (rsp_overflow !== oldest_score.overflow) begin
               $error("overflow: expected %0d, got %0d", oldest_score.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("edit_distance_similarity_top_tb failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_strings();
      test_thresholds();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      if (expected_scores.size() != 0) begin
         $error("%0d result words never arrived", expected_scores.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("edit_distance_similarity_top_tb passed");
      end else begin
         $display("edit_distance_similarity_top_tb failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/edsim_pkg.sv
rtl/edsim_ram.sv
rtl/edsim_cell.sv
rtl/edsim_match.sv
rtl/edit_distance_similarity_top.sv
verif/edit_distance_similarity_top_tb.sv
